// File: design/vpw_pkg.sv
// Shared constants for the vertex projection pipeline: field widths, register
// indexes and datapath widths. No dependencies.
package vpw_pkg;

  localparam int unsigned CoordW = 32;          // Q16.16 coordinate
  localparam int unsigned CoefW  = 16;          // Q4.12 coefficient
  localparam int unsigned RowW   = 64;          // one matrix row register
  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOrigin = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSize   = 3'd5;

  localparam logic [RowW-1:0] Row0Reset = 64'h0000_0000_0000_1000;
  localparam logic [RowW-1:0] Row1Reset = 64'h0000_0000_1000_0000;
  localparam logic [RowW-1:0] Row2Reset = 64'h0000_1000_0000_0000;
  localparam logic [RowW-1:0] Row3Reset = 64'h1000_0000_0000_0000;

  localparam int unsigned ProdW  = CoordW + CoefW;   // Q.28 product
  localparam int unsigned ClipW  = 52;               // clip coordinate, signed
  localparam int unsigned MagW   = 52;               // |cw + c| and |cw|
  localparam int unsigned ScaleW = 31;               // size * 2^15
  localparam int unsigned PloW   = 32 + ScaleW;
  localparam int unsigned PhiW   = (MagW - 32) + ScaleW;
  localparam int unsigned NumW   = 84;               // scaled numerator
  localparam int unsigned QuoW   = 41;               // quotient bits developed
  localparam int unsigned RemW   = MagW + 1;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned RndW   = QuoW + 1;
  localparam int unsigned SgnW   = RndW + 1;         // signed, magnitude <= 2^40
  localparam int unsigned Lanes  = 3;                // x, y, depth

  localparam logic [RndW-1:0] QCap = RndW'(1) << 40;

endpackage

// File: design/vertex_project_to_window.sv
// Vertex projection to window coordinates: matrix multiply, perspective divide
// and viewport mapping as one register pipeline. Depends on vpw_pkg.
//
// An input beat passes 51 registers in line, the last one the output register.
// One beat per cycle while the skid register is empty; the 42 divider stages (an
// entry check, then one quotient bit each) set the depth.
// Reset clears all valid bits, the output and skid registers, and loads the
// identity matrix with a zero viewport; payload registers are not reset.
module vertex_project_to_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [vpw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vpw_pkg::RowW-1:0]      cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,   // obj_x, obj_y, obj_z
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [95:0]                   m_axis_tdata,   // win_x, win_y, win_depth
  output logic                          m_axis_tuser    // proj_valid
);

  localparam int unsigned L  = vpw_pkg::Lanes;
  localparam int unsigned DS = vpw_pkg::DivSteps;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [vpw_pkg::RowW-1:0] row_q [4];
  logic [31:0]              origin_q;
  logic [31:0]              size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= vpw_pkg::Row0Reset;
      row_q[1] <= vpw_pkg::Row1Reset;
      row_q[2] <= vpw_pkg::Row2Reset;
      row_q[3] <= vpw_pkg::Row3Reset;
      origin_q <= '0;
      size_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vpw_pkg::RegRow0:   row_q[0] <= cfg_data_i;
        vpw_pkg::RegRow1:   row_q[1] <= cfg_data_i;
        vpw_pkg::RegRow2:   row_q[2] <= cfg_data_i;
        vpw_pkg::RegRow3:   row_q[3] <= cfg_data_i;
        vpw_pkg::RegOrigin: origin_q <= cfg_data_i[31:0];
        vpw_pkg::RegSize:   size_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; it freezes only while the skid
  // register holds a beat, so one result can wait while the next one is taken.
  logic adv;
  logic skid_v_q;
  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Stage 1: twelve coefficient products (Q16.16 x Q4.12 = Q.28)
  // ---------------------------------------------------------------------------
  logic                              v1_q;
  logic signed [vpw_pkg::ProdW-1:0]  prod_q [4][3];
  logic signed [vpw_pkg::CoefW-1:0]  c3_q   [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= $signed(s_axis_tdata[32*j +: 32]) *
                          $signed(row_q[i][16*j +: 16]);
        end
        c3_q[i] <= $signed(row_q[i][63:48]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clip coordinates; the w column joins shifted up to Q.28
  // ---------------------------------------------------------------------------
  logic                              v2_q;
  logic signed [vpw_pkg::ClipW-1:0]  clip_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        clip_q[i] <= vpw_pkg::ClipW'(prod_q[i][0]) + vpw_pkg::ClipW'(prod_q[i][1]) +
                     vpw_pkg::ClipW'(prod_q[i][2]) +
                     vpw_pkg::ClipW'($signed({c3_q[i], 16'h0000}));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: numerators cw + c as sign and magnitude, divisor |cw|
  // ---------------------------------------------------------------------------
  logic                             v3_q;
  logic [vpw_pkg::MagW-1:0]         mag_q [L];
  logic [L-1:0]                     neg3_q;
  logic [vpw_pkg::MagW-1:0]         d3_q;
  logic                             wz3_q;

  always_ff @(posedge clk_i) begin
    logic signed [vpw_pkg::ClipW:0] a;
    logic signed [vpw_pkg::ClipW:0] cw;
    if (adv) begin
      cw = (vpw_pkg::ClipW+1)'(clip_q[3]);
      for (int l = 0; l < L; l++) begin
        a = cw + (vpw_pkg::ClipW+1)'(clip_q[l]);
        mag_q[l]  <= a[vpw_pkg::ClipW] ? vpw_pkg::MagW'(-a) : vpw_pkg::MagW'(a);
        neg3_q[l] <= a[vpw_pkg::ClipW] ^ cw[vpw_pkg::ClipW];
      end
      d3_q  <= cw[vpw_pkg::ClipW] ? vpw_pkg::MagW'(-cw) : vpw_pkg::MagW'(cw);
      wz3_q <= (clip_q[3] == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: partial products of the magnitude and the viewport scale
  // ---------------------------------------------------------------------------
  logic                             v4_q;
  logic [vpw_pkg::PloW-1:0]         plo_q [L];
  logic [vpw_pkg::PhiW-1:0]         phi_q [L];
  logic [L-1:0]                     neg4_q;
  logic [vpw_pkg::MagW-1:0]         d4_q;
  logic                             wz4_q;
  logic [vpw_pkg::ScaleW-1:0]       scale [L];

  assign scale[0] = {size_q[15:0], 15'h0000};
  assign scale[1] = {size_q[31:16], 15'h0000};
  assign scale[2] = vpw_pkg::ScaleW'(1) << 15;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        plo_q[l] <= mag_q[l][31:0] * scale[l];
        phi_q[l] <= mag_q[l][vpw_pkg::MagW-1:32] * scale[l];
      end
      neg4_q <= neg3_q;
      d4_q   <= d3_q;
      wz4_q  <= wz3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: combine the partial products into the full numerator
  // ---------------------------------------------------------------------------
  logic                             v5_q;
  logic [vpw_pkg::NumW-1:0]         num_q [L];
  logic [L-1:0]                     neg5_q;
  logic [vpw_pkg::MagW-1:0]         d5_q;
  logic                             wz5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        num_q[l] <= vpw_pkg::NumW'(plo_q[l]) + (vpw_pkg::NumW'(phi_q[l]) << 32);
      end
      neg5_q <= neg4_q;
      d5_q   <= d4_q;
      wz5_q  <= wz4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: entry stage flags quotients of 2^41 or more, then one quotient
  // bit per stage. Index 0 is the entry stage, DS the last step.
  // ---------------------------------------------------------------------------
  logic [DS:0]                 dv_q;
  logic [vpw_pkg::RemW-1:0]    dr_q  [DS+1][L];
  logic [vpw_pkg::RemW-1:0]    dr_d  [DS+1][L];
  logic [vpw_pkg::QuoW-1:0]    dq_q  [DS+1][L];
  logic [vpw_pkg::QuoW-1:0]    dq_d  [DS+1][L];
  logic [vpw_pkg::QuoW-1:0]    dn_q  [DS+1][L];
  logic [vpw_pkg::QuoW-1:0]    dn_d  [DS+1][L];
  logic [L-1:0]                dovf_q [DS+1];
  logic [L-1:0]                dneg_q [DS+1];
  logic [vpw_pkg::MagW-1:0]    dd_q   [DS+1];
  logic [DS:0]                 dwz_q;

  always_comb begin
    logic [vpw_pkg::NumW-vpw_pkg::QuoW-1:0] top;
    logic [vpw_pkg::RemW-1:0]               t;
    // entry: high part of the numerator is the first partial remainder
    for (int l = 0; l < L; l++) begin
      top = num_q[l][vpw_pkg::NumW-1:vpw_pkg::QuoW];
      dr_d[0][l] = (vpw_pkg::MagW'(top) >= d5_q) ? '0 : vpw_pkg::RemW'(top);
      dq_d[0][l] = '0;
      dn_d[0][l] = num_q[l][vpw_pkg::QuoW-1:0];
    end
    // one restoring step per stage
    for (int k = 1; k <= DS; k++) begin
      for (int l = 0; l < L; l++) begin
        t = {dr_q[k-1][l][vpw_pkg::RemW-2:0], dn_q[k-1][l][vpw_pkg::QuoW-1]};
        if (t >= vpw_pkg::RemW'(dd_q[k-1])) begin
          dr_d[k][l] = t - vpw_pkg::RemW'(dd_q[k-1]);
          dq_d[k][l] = {dq_q[k-1][l][vpw_pkg::QuoW-2:0], 1'b1};
        end else begin
          dr_d[k][l] = t;
          dq_d[k][l] = {dq_q[k-1][l][vpw_pkg::QuoW-2:0], 1'b0};
        end
        dn_d[k][l] = {dn_q[k-1][l][vpw_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DS; k++) begin
        dr_q[k] <= dr_d[k];
        dq_q[k] <= dq_d[k];
        dn_q[k] <= dn_d[k];
      end
      for (int l = 0; l < L; l++) begin
        dovf_q[0][l] <= vpw_pkg::MagW'(num_q[l][vpw_pkg::NumW-1:vpw_pkg::QuoW]) >=
                        d5_q;
      end
      dneg_q[0] <= neg5_q;
      dd_q[0]   <= d5_q;
      dwz_q[0]  <= wz5_q;
      for (int k = 1; k <= DS; k++) begin
        dovf_q[k] <= dovf_q[k-1];
        dneg_q[k] <= dneg_q[k-1];
        dd_q[k]   <= dd_q[k-1];
        dwz_q[k]  <= dwz_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Round: nearest, ties away from zero, on the magnitude
  // ---------------------------------------------------------------------------
  logic                         vr1_q;
  logic [vpw_pkg::RndW-1:0]     qr_q [L];
  logic [L-1:0]                 ovf1_q;
  logic [L-1:0]                 neg6_q;
  logic                         wz6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        qr_q[l] <= vpw_pkg::RndW'(dq_q[DS][l]) +
                   vpw_pkg::RndW'({dr_q[DS][l], 1'b0} >= {2'b00, dd_q[DS]});
      end
      ovf1_q <= dovf_q[DS];
      neg6_q <= dneg_q[DS];
      wz6_q  <= dwz_q[DS];
    end
  end

  // ---------------------------------------------------------------------------
  // Clamp the magnitude to 2^40 and apply the sign
  // ---------------------------------------------------------------------------
  logic                               vr2_q;
  logic signed [vpw_pkg::SgnW-1:0]    sv_q [L];
  logic                               wz7_q;

  always_ff @(posedge clk_i) begin
    logic [vpw_pkg::RndW-1:0] m;
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        m = (ovf1_q[l] || qr_q[l] > vpw_pkg::QCap) ? vpw_pkg::QCap : qr_q[l];
        sv_q[l] <= neg6_q[l] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      end
      wz7_q <= wz6_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Add the origin, saturate to Q16.16, force zero when clip w was zero
  // ---------------------------------------------------------------------------
  logic        vr3_q;
  logic [95:0] res_q;
  logic        resv_q;
  logic signed [31:0] org [L];

  assign org[0] = {origin_q[15:0], 16'h0000};
  assign org[1] = {origin_q[31:16], 16'h0000};
  assign org[2] = '0;

  always_ff @(posedge clk_i) begin
    logic signed [vpw_pkg::SgnW:0] s;
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        s = (vpw_pkg::SgnW+1)'(org[l]) + (vpw_pkg::SgnW+1)'(sv_q[l]);
        if (wz7_q) begin
          res_q[32*l +: 32] <= '0;
        end else if (s > (vpw_pkg::SgnW+1)'(32'sh7FFF_FFFF)) begin
          res_q[32*l +: 32] <= 32'h7FFF_FFFF;
        end else if (s < -(vpw_pkg::SgnW+1)'(33'sh0_8000_0000)) begin
          res_q[32*l +: 32] <= 32'h8000_0000;
        end else begin
          res_q[32*l +: 32] <= s[31:0];
        end
      end
      resv_q <= !wz7_q;
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      dv_q  <= '0;
      vr1_q <= 1'b0;
      vr2_q <= 1'b0;
      vr3_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= in_beat;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      dv_q  <= {dv_q[DS-1:0], v5_q};
      vr1_q <= dv_q[DS];
      vr2_q <= vr1_q;
      vr3_q <= vr2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with a skid stage behind it
  // ---------------------------------------------------------------------------
  logic        out_v_q;
  logic [95:0] out_data_q;
  logic        out_user_q;
  logic [95:0] skid_data_q;
  logic        skid_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
      skid_v_q    <= 1'b0;
      skid_data_q <= '0;
      skid_user_q <= 1'b0;
    end else if (m_axis_tready || !out_v_q) begin
      if (skid_v_q) begin
        // drain the parked beat first
        out_v_q    <= 1'b1;
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
        skid_v_q   <= 1'b0;
      end else begin
        out_v_q    <= vr3_q;
        out_data_q <= res_q;
        out_user_q <= resv_q;
      end
    end else if (vr3_q && adv) begin
      // output held: park the arriving beat
      skid_v_q    <= 1'b1;
      skid_data_q <= res_q;
      skid_user_q <= resv_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while the output register is empty");

  a_skid_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !m_axis_tready) |=> skid_v_q)
    else $error("parked beat lost without handoff");

  a_unprojected_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("unprojected result carries nonzero coordinates");

endmodule

// File: dv/vertex_project_to_window_test.sv
// Self-checking testbench for vertex_project_to_window: drives vertex beats,
// predicts each window-space result and compares it field by field.
// Depends on vpw_pkg and the vertex_project_to_window RTL.
module vertex_project_to_window_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] depth;
    logic [31:0] wy;
    logic [31:0] wx;
    logic        valid;
  } window_pt_t;

  localparam int unsigned SettleCycles = 60;   // pipeline depth plus margin
  localparam longint unsigned RatioCap = 64'd1 << 40;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [vpw_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [vpw_pkg::RowW-1:0]    cfg_data_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [95:0]                 s_axis_tdata = '0;     // obj_x, obj_y, obj_z
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [95:0]                 m_axis_tdata;          // win_x, win_y, win_depth
  logic                        m_axis_tuser;          // proj_valid

  vertex_project_to_window dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the configuration registers
  logic [vpw_pkg::RowW-1:0] mat_rows [4];
  logic [31:0]              vp_origin;
  logic [31:0]              vp_size;

  window_pt_t pending_pts[$];
  int unsigned error_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned snk_hold_cycles = 0;

  function automatic logic [31:0] clamp_q16(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // round(num * mul / den) to nearest, ties away from zero, magnitude capped
  function automatic longint round_ratio(longint num, longint unsigned mul, longint den);
    longint unsigned nm, dm;
    logic [127:0] prod, quo, rem, dw;
    bit neg;
    nm = (num < 0) ? longint'(-num) : num;
    dm = (den < 0) ? longint'(-den) : den;
    neg = (num < 0) != (den < 0);
    dw = dm;
    prod = 128'(nm) * 128'(mul);
    quo = prod / dw;
    rem = prod % dw;
    if (rem >= dw - rem) quo = quo + 1;
    if (quo > 128'(RatioCap)) quo = RatioCap;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic window_pt_t project_point(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz);
    window_pt_t res;
    longint clip [4];
    longint pt [3];
    longint cw, ox, oy;
    pt[0] = longint'($signed(px));
    pt[1] = longint'($signed(py));
    pt[2] = longint'($signed(pz));
    for (int i = 0; i < 4; i++) begin
      clip[i] = longint'($signed(mat_rows[i][63:48])) * 65536;
      for (int j = 0; j < 3; j++)
        clip[i] += pt[j] * longint'($signed(mat_rows[i][16*j +: 16]));
    end
    cw = clip[3];
    res = '0;
    if (cw == 0) return res;
    ox = longint'($signed(vp_origin[15:0]));
    oy = longint'($signed(vp_origin[31:16]));
    res.wx = clamp_q16(ox * 65536 +
                       round_ratio(cw + clip[0], longint'(vp_size[15:0]) << 15, cw));
    res.wy = clamp_q16(oy * 65536 +
                       round_ratio(cw + clip[1], longint'(vp_size[31:16]) << 15, cw));
    res.depth = clamp_q16(round_ratio(cw + clip[2], 64'd1 << 15, cw));
    res.valid = 1'b1;
    return res;
  endfunction

  // Receiver: random backpressure, or a counted hold-off when requested.
  always @(posedge clk_i) begin
    if (snk_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      snk_hold_cycles <= snk_hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Compare each output beat against the oldest prediction.
  always @(posedge clk_i) begin
    window_pt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected output beat %h user %b", $time, m_axis_tdata,
                 m_axis_tuser);
        error_count++;
      end else begin
        want = pending_pts.pop_front();
        if (m_axis_tdata[31:0] !== want.wx) begin
          $display("%0t: win_x expected %h actual %h", $time, want.wx, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[63:32] !== want.wy) begin
          $display("%0t: win_y expected %h actual %h", $time, want.wy, m_axis_tdata[63:32]);
          error_count++;
        end
        if (m_axis_tdata[95:64] !== want.depth) begin
          $display("%0t: win_depth expected %h actual %h", $time, want.depth,
                   m_axis_tdata[95:64]);
          error_count++;
        end
        if (m_axis_tuser !== want.valid) begin
          $display("%0t: proj_valid expected %b actual %b", $time, want.valid, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // Offer one vertex beat, hold it until accepted, record its prediction.
  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    pending_pts.push_back(project_point(px, py, pz));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every predicted beat has come out, then let the pipe settle.
  task automatic drain();
    end_burst();
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register, then drop the enable.
  task automatic write_reg(logic [vpw_pkg::CfgIdxW-1:0] idx,
                           logic [vpw_pkg::RowW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx <= vpw_pkg::RegRow3) mat_rows[idx[1:0]] = val;
    else if (idx == vpw_pkg::RegOrigin) vp_origin = val[31:0];
    else if (idx == vpw_pkg::RegSize) vp_size = val[31:0];
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(8192)) - 16'd4096;   // within +-1.0
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      default: return $urandom();
    endcase
  endfunction

  task automatic load_random_config();
    logic [vpw_pkg::RowW-1:0] row;
    for (int i = 0; i < 4; i++) begin
      row = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      write_reg(vpw_pkg::CfgIdxW'(i), row);
    end
    write_reg(vpw_pkg::RegOrigin, {32'h0, $urandom()});
    case ($urandom_range(3))
      0: write_reg(vpw_pkg::RegSize, {32'h0, 32'hFFFF_FFFF});
      1: write_reg(vpw_pkg::RegSize, 64'h0);
      default: write_reg(vpw_pkg::RegSize, {32'h0, $urandom()});
    endcase
  endtask

  // Reset values: identity matrix, empty viewport at origin zero.
  task automatic test_reset_defaults();
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_vertex(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  // Directed corners: field extremes, zero clip w, zero and full viewport.
  task automatic test_directed_corners();
    write_reg(vpw_pkg::RegRow0, 64'h0000_0000_0000_1000);
    write_reg(vpw_pkg::RegRow1, 64'h0000_0000_1000_0000);
    write_reg(vpw_pkg::RegRow2, 64'h0000_1000_0000_0000);
    write_reg(vpw_pkg::RegRow3, 64'h1000_0000_0000_0000);
    write_reg(vpw_pkg::RegOrigin, 64'h0000_0000_8000_7FFF);
    write_reg(vpw_pkg::RegSize, 64'h0000_0000_FFFF_FFFF);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000);
    send_vertex(32'h0, 32'h0, 32'h7FFF_FFFF);
    drain();
    // w row zero: no projection possible
    write_reg(vpw_pkg::RegRow3, 64'h0);
    send_vertex(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    // w depends on z only: zero at z = 0, sign opposite to z elsewhere
    write_reg(vpw_pkg::RegRow3, 64'h0000_8000_0000_0000);
    write_reg(vpw_pkg::RegSize, 64'h0);
    write_reg(vpw_pkg::RegOrigin, 64'h0000_0000_7FFF_8000);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0000_0001);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    drain();
    // extreme coefficients with a tiny w: saturating quotients
    write_reg(vpw_pkg::RegRow0, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(vpw_pkg::RegRow1, 64'h8000_8000_8000_8000);
    write_reg(vpw_pkg::RegRow2, 64'h7FFF_8000_7FFF_8000);
    write_reg(vpw_pkg::RegRow3, 64'h0001_0000_0000_0000);
    write_reg(vpw_pkg::RegSize, 64'h0000_0000_FFFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();
  endtask

  // Receiver holds off long enough to fill the pipe and stall the input.
  task automatic test_backpressure_fill();
    load_random_config();
    src_idle_pct = 0;
    snk_hold_cycles = 400;
    repeat (150) send_vertex(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  // Random vertices under several configurations and idle profiles.
  task automatic test_random_stream(int unsigned src_pct, int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int p = 0; p < 5; p++) begin
      load_random_config();
      repeat (75) send_vertex(rand_coord(), rand_coord(), rand_coord());
      // pause the source until all results are back after every configuration
      if (p == 2) drain();
      else end_burst();
      drain();
    end
  endtask

  initial begin
    mat_rows[0] = vpw_pkg::Row0Reset;
    mat_rows[1] = vpw_pkg::Row1Reset;
    mat_rows[2] = vpw_pkg::Row2Reset;
    mat_rows[3] = vpw_pkg::Row3Reset;
    vp_origin = '0;
    vp_size = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_corners();
    test_random_stream(15, 88);
    test_random_stream(88, 15);
    test_random_stream(0, 0);
    test_backpressure_fill();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    drain();
    if (error_count == 0 && pending_pts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: vertex_project_to_window.f
design/vpw_pkg.sv
design/vertex_project_to_window.sv
dv/vertex_project_to_window_test.sv
